/* sv/adt_pkg.sv */
// -----------------------------------------------------------------------------
// adt_pkg
// Shared types, codes and constants of the alert de-duplication table.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adt_pkg;

  localparam int          SLOTS_DEF    = 24;
  localparam int          ADDR_W       = 24;
  localparam int          TIME_W       = 32;
  localparam int          KIND_W       = 2;
  localparam int          SLOT_W       = ADDR_W + TIME_W;
  localparam logic [31:0] EXPIRY_RESET = 32'd600000;

  // item modes
  localparam logic [1:0] MODE_AIRCRAFT = 2'd0;
  localparam logic [1:0] MODE_CONSUME  = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  // alert kinds, ordered by priority
  localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTABLE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MILITARY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMERGENCY = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] aircraft_address;
    logic              address_present;
    logic [2:0]        alert_bits;
    logic [TIME_W-1:0] now_ms;
    logic              sweep_last;
  } adt_in_t;

  typedef struct packed {
    logic              announced;
    logic [KIND_W-1:0] item_kind;
    logic [KIND_W-1:0] pending_kind;
    logic [KIND_W-1:0] taken_kind;
    logic              sweep_done;
  } adt_out_t;

  // one remembered aircraft as held in the slot memory
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] stamp;
  } slot_t;

  // highest alert bit wins
  function automatic logic [KIND_W-1:0] kind_of(input logic [2:0] bits);
    logic [KIND_W-1:0] k;
    if (bits[2]) begin
      k = KIND_EMERGENCY;
    end else if (bits[1]) begin
      k = KIND_MILITARY;
    end else if (bits[0]) begin
      k = KIND_NOTABLE;
    end else begin
      k = KIND_NONE;
    end
    return k;
  endfunction

endpackage

/* sv/adt_ram.sv */
// -----------------------------------------------------------------------------
// adt_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/alert_dedup_table_top.sv */
// Consume/clear/other items and skipped aircraft go straight to ST_FIN, which hands the
// result to the output register once it is free. Aircraft lookup walks the slot memory
// one read per cycle: a recent match refreshes that slot's time and ends the walk; a miss
// or expired match adds an insertion walk. One item in flight; in_ready is high only when
// idle, so a new item is not taken before the last result reaches the output register.
// Reset (synchronous, rst_n low) empties the table via per-slot valid flops, clears the
// pending kind and loads expiry_r with 600000; no clearing pass follows.
// -----------------------------------------------------------------------------
// alert_dedup_table_top
// Recently-seen filter with expiry for aircraft alerts, one shared compare
// unit stepped over the slot memory by a small sequencer.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alert_dedup_table_top
  import adt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  adt_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output adt_out_t    out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_INS  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              have_best_r, have_best_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0] best_time_r, best_time_nxt;
  adt_in_t           item_r, item_nxt;
  adt_out_t          res_r, res_nxt;
  logic [KIND_W-1:0] pending_r, pending_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [31:0]       expiry_r, expiry_nxt;
  logic              out_valid_r, out_valid_nxt;
  adt_out_t          out_data_r, out_data_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wslot;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  slot_t             rd_slot;
  logic              hit;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              take;
  logic [IDX_W-1:0]  ins_idx;
  logic              do_insert;
  logic [KIND_W-1:0] item_kind;

  adt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared compare unit on the slot read back this cycle
  always_comb begin
    rd_slot = slot_t'(ram_rdata);
    hit     = cmp_vld_r && valid_r[cmp_idx_r] && (rd_slot.addr == item_r.aircraft_address);
    age     = item_r.now_ms - rd_slot.stamp;
    expired = age > expiry_r;
    take    = !have_best_r || (rd_slot.stamp < best_time_r);
  end

  assign item_kind = kind_of(in_data.alert_bits);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    have_best_nxt = have_best_r;
    best_idx_nxt  = best_idx_r;
    best_time_nxt = best_time_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    pending_nxt   = pending_r;
    valid_nxt     = valid_r;
    expiry_nxt    = expiry_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cmp_idx_r;
    ram_wslot     = '{addr: item_r.aircraft_address, stamp: item_r.now_ms};
    ram_raddr     = '0;
    do_insert     = 1'b0;
    ins_idx       = cmp_idx_r;

    // drop a beat the sink has taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      expiry_nxt = cfg_wdata;
    end

    // issue one slot read per cycle while walking the table
    if ((state_r == ST_LOOK || state_r == ST_INS) && cnt_r != CNT_END) begin
      ram_raddr   = cnt_r[IDX_W-1:0];
      cnt_nxt     = cnt_r + 1'b1;
      cmp_vld_nxt = 1'b1;
      cmp_idx_nxt = cnt_r[IDX_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt           = in_data;
          res_nxt            = '0;
          res_nxt.sweep_done = in_data.sweep_last;
          res_nxt.pending_kind = pending_r;
          state_nxt          = ST_FIN;
          case (in_data.mode)
            MODE_AIRCRAFT: begin
              res_nxt.item_kind = item_kind;
              if (item_kind != KIND_NONE && in_data.address_present) begin
                state_nxt   = ST_LOOK;
                cnt_nxt     = '0;
                cmp_vld_nxt = 1'b0;
              end
            end
            MODE_CONSUME: begin
              res_nxt.taken_kind   = pending_r;
              res_nxt.pending_kind = KIND_NONE;
              pending_nxt          = KIND_NONE;
            end
            MODE_CLEAR: begin
              res_nxt.pending_kind = KIND_NONE;
              pending_nxt          = KIND_NONE;
              valid_nxt            = '0;
            end
            default: begin
              res_nxt.pending_kind = pending_r;
            end
          endcase
        end
      end

      ST_LOOK: begin
        if (hit) begin
          // refresh the matching slot's time
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_r;
          if (expired) begin
            state_nxt     = ST_INS;
            cnt_nxt       = '0;
            cmp_vld_nxt   = 1'b0;
            have_best_nxt = 1'b0;
          end else begin
            state_nxt = ST_FIN;
          end
        end else if (cmp_vld_r && cmp_idx_r == LAST_IDX) begin
          state_nxt     = ST_INS;
          cnt_nxt       = '0;
          cmp_vld_nxt   = 1'b0;
          have_best_nxt = 1'b0;
        end
      end

      ST_INS: begin
        if (cmp_vld_r) begin
          if (!valid_r[cmp_idx_r]) begin
            // first empty slot wins
            do_insert = 1'b1;
            ins_idx   = cmp_idx_r;
          end else begin
            if (take) begin
              have_best_nxt = 1'b1;
              best_idx_nxt  = cmp_idx_r;
              best_time_nxt = rd_slot.stamp;
            end
            if (cmp_idx_r == LAST_IDX) begin
              do_insert = 1'b1;
              ins_idx   = take ? cmp_idx_r : best_idx_r;
            end
          end
        end
        if (do_insert) begin
          ram_we               = 1'b1;
          ram_waddr            = ins_idx;
          valid_nxt[ins_idx]   = 1'b1;
          res_nxt.announced    = 1'b1;
          if (res_r.item_kind > pending_r) begin
            pending_nxt          = res_r.item_kind;
            res_nxt.pending_kind = res_r.item_kind;
          end else begin
            res_nxt.pending_kind = pending_r;
          end
          state_nxt            = ST_FIN;
        end
      end

      ST_FIN: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      have_best_r <= 1'b0;
      pending_r   <= KIND_NONE;
      valid_r     <= '0;
      expiry_r    <= EXPIRY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      have_best_r <= have_best_nxt;
      pending_r   <= pending_nxt;
      valid_r     <= valid_nxt;
      expiry_r    <= expiry_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_time_r <= best_time_nxt;
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/adt_checker.sv */
// -----------------------------------------------------------------------------
// adt_checker
// Port-level checks of the alert de-duplication table results.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adt_checker
  import adt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input adt_out_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a consume beat leaves nothing pending
  a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.taken_kind != KIND_NONE |-> out_data.pending_kind == KIND_NONE)
    else $error("pending kind not cleared by consume");

  // an announcement has a kind and raises the pending kind to it
  a_announce_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.announced |->
      out_data.item_kind != KIND_NONE && out_data.pending_kind >= out_data.item_kind)
    else $error("announcement without matching pending kind");

  // an announcement never returns a taken kind
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.announced |-> out_data.taken_kind == KIND_NONE)
    else $error("announcement and consume in one beat");

endmodule

bind alert_dedup_table_top adt_checker u_adt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/alert_dedup_checker.sv */
// -----------------------------------------------------------------------------
// alert_dedup_checker
// Watches the item, result and register ports of the alert de-duplication
// table. It keeps its own slot table, pending kind and expiry, predicts one
// result per accepted item and compares each result beat with the oldest
// prediction. Failures and the number of results still owed go to the top.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alert_dedup_checker
  import adt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  adt_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  adt_out_t    out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_cnt,
  output int          owed_cnt
);

  // shadow of the slot table
  logic [ADDR_W-1:0] seen_addr  [SLOTS];
  logic              seen_used  [SLOTS];
  logic [TIME_W-1:0] seen_stamp [SLOTS];
  logic [KIND_W-1:0] held_kind;
  logic [31:0]       expiry_ms;

  adt_out_t owed_results[$];
  int       n_fail;
  int       n_beat;

  // work out the result of one item and advance the shadow state
  task automatic predict_announce(input adt_in_t it, output adt_out_t res);
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] age;
    int                hit;
    int                victim;
    logic              fresh;
    res            = '0;
    res.sweep_done = it.sweep_last;
    case (it.mode)
      MODE_AIRCRAFT: begin
        if (it.alert_bits[2]) begin
          kind = KIND_EMERGENCY;
        end else if (it.alert_bits[1]) begin
          kind = KIND_MILITARY;
        end else if (it.alert_bits[0]) begin
          kind = KIND_NOTABLE;
        end else begin
          kind = KIND_NONE;
        end
        res.item_kind = kind;
        if (kind != KIND_NONE && it.address_present) begin
          // look up the first live slot holding this address
          hit = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && seen_used[i] && seen_addr[i] == it.aircraft_address) begin
              hit = i;
            end
          end
          fresh = 1'b0;
          if (hit >= 0) begin
            age             = it.now_ms - seen_stamp[hit];
            seen_stamp[hit] = it.now_ms;
            fresh           = (age <= expiry_ms);
          end
          if (!fresh) begin
            // first empty slot, else the first oldest stamp
            victim = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (!seen_used[i]) begin
                victim = i;
                break;
              end
              if (victim < 0 || seen_stamp[i] < seen_stamp[victim]) begin
                victim = i;
              end
            end
            seen_used[victim]  = 1'b1;
            seen_addr[victim]  = it.aircraft_address;
            seen_stamp[victim] = it.now_ms;
            res.announced      = 1'b1;
            if (kind > held_kind) begin
              held_kind = kind;
            end
          end
        end
      end
      MODE_CONSUME: begin
        res.taken_kind = held_kind;
        held_kind      = KIND_NONE;
      end
      MODE_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          seen_used[i] = 1'b0;
        end
        held_kind = KIND_NONE;
      end
      default: begin
      end
    endcase
    res.pending_kind = held_kind;
  endtask

  always @(posedge clk) begin : watch
    adt_out_t want;
    adt_out_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        seen_used[i] = 1'b0;
      end
      held_kind = KIND_NONE;
      expiry_ms = EXPIRY_RESET;
      owed_results.delete();
      n_fail    = 0;
      n_beat    = 0;
    end else begin
      if (cfg_we) begin
        expiry_ms = cfg_wdata;
      end
      // predict on every accepted item beat
      if (in_valid && in_ready) begin
        predict_announce(in_data, want);
        owed_results.push_back(want);
      end
      // compare every accepted result beat
      if (out_valid && out_ready) begin
        got = out_data;
        if (owed_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("[%0t] result beat with nothing outstanding: ann=%0b kind=%0d pend=%0d taken=%0d sweep=%0b",
                     $time, got.announced, got.item_kind, got.pending_kind,
                     got.taken_kind, got.sweep_done);
          end
        end else begin
          want = owed_results.pop_front();
          if (got.announced !== want.announced || got.item_kind !== want.item_kind ||
              got.pending_kind !== want.pending_kind || got.taken_kind !== want.taken_kind ||
              got.sweep_done !== want.sweep_done) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("[%0t] result %0d mismatch: want ann=%0b kind=%0d pend=%0d taken=%0d sweep=%0b",
                       $time, n_beat, want.announced, want.item_kind, want.pending_kind,
                       want.taken_kind, want.sweep_done);
              $display("    got ann=%0b kind=%0d pend=%0d taken=%0d sweep=%0b",
                       got.announced, got.item_kind, got.pending_kind,
                       got.taken_kind, got.sweep_done);
            end
          end
          n_beat++;
        end
      end
    end
    fail_cnt <= n_fail;
    owed_cnt <= owed_results.size();
  end

endmodule

/* sim/tb_alert_dedup_table_top.sv */
// -----------------------------------------------------------------------------
// tb_alert_dedup_table_top
// Drives the alert de-duplication table with a directed opening (kinds,
// address and time extremes, expiry boundaries, wrap of the time difference,
// consume, clear and ignored items) and then random sweeps over a small fleet
// of addresses under several expiry settings and idle patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_alert_dedup_table_top;
  import adt_pkg::*;

  localparam logic [1:0] MODE_IGNORED  = 2'd3;
  localparam int         QUIET_LIMIT   = 4000;
  localparam int         SEGMENTS      = 6;
  localparam int         SEGMENT_ITEMS = 258;
  localparam int         FLEET         = 32;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  adt_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  adt_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int fail_cnt;
  int owed_cnt;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  logic [ADDR_W-1:0] fleet [FLEET];

  alert_dedup_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  alert_dedup_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_cnt  (fail_cnt),
    .owed_cnt  (owed_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_alert_dedup_table_top: errors");
        $finish;
      end
    end
  end

  function automatic adt_in_t mk_item(input logic [1:0] mode, input logic [ADDR_W-1:0] addr,
                                      input logic present, input logic [2:0] bits,
                                      input logic [TIME_W-1:0] now, input logic last);
    adt_in_t it;
    it.mode             = mode;
    it.aircraft_address = addr;
    it.address_present  = present;
    it.alert_bits       = bits;
    it.now_ms           = now;
    it.sweep_last       = last;
    return it;
  endfunction

  // offer one item beat, idling first at random; valid stays up between beats
  task automatic send_item(input adt_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_cnt != 0);
  endtask

  task automatic write_expiry(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stim
    logic [31:0]       expiry_set [SEGMENTS];
    logic [31:0]       exp_now;
    logic [31:0]       span;
    logic [TIME_W-1:0] cur_ms;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        mode;
    int                r;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening under the reset expiry
    send_item(mk_item(MODE_IGNORED, 24'h5A5A5A, 1'b1, 3'b111, 32'h1234_5678, 1'b1));
    send_item(mk_item(MODE_CONSUME, 24'h000000, 1'b0, 3'b000, 32'h0, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b001, 32'h0, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'hFFFFFF, 1'b1, 3'b010, 32'hFFFF_FFFF, 1'b1));
    // age equal to the expiry: suppressed; one more: announced again
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b100, EXPIRY_RESET, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b111, 2 * EXPIRY_RESET + 1, 1'b0));
    // time difference across the 32-bit wrap
    send_item(mk_item(MODE_AIRCRAFT, 24'hFFFFFF, 1'b1, 3'b011, EXPIRY_RESET - 1, 1'b1));
    send_item(mk_item(MODE_AIRCRAFT, 24'hFFFFFF, 1'b1, 3'b011, 3 * EXPIRY_RESET, 1'b1));
    // skipped aircraft: no address, then no alert bits
    send_item(mk_item(MODE_AIRCRAFT, 24'h123456, 1'b0, 3'b111, 32'h0000_1000, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'h123456, 1'b1, 3'b000, 32'h0000_1000, 1'b1));
    send_item(mk_item(MODE_CONSUME, 24'hFFFFFF, 1'b1, 3'b111, 32'hFFFF_FFFF, 1'b1));
    send_item(mk_item(MODE_CONSUME, 24'h000000, 1'b0, 3'b000, 32'h0, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'hABCDEF, 1'b1, 3'b110, 32'h8000_0000, 1'b1));
    send_item(mk_item(MODE_IGNORED, 24'h000000, 1'b0, 3'b000, 32'h0, 1'b0));
    send_item(mk_item(MODE_CLEAR, 24'h000000, 1'b0, 3'b000, 32'h0, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b101, 32'h0, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b001, 32'h0, 1'b1));
    send_item(mk_item(MODE_CONSUME, 24'h000000, 1'b0, 3'b000, 32'h0, 1'b0));

    // zero expiry: same time suppressed, one millisecond later announced
    wait_drained();
    write_expiry(32'h0);
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b001, 32'h0, 1'b0));
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b001, 32'h1, 1'b0));
    // largest expiry: nothing ever expires
    wait_drained();
    write_expiry(32'hFFFF_FFFF);
    send_item(mk_item(MODE_AIRCRAFT, 24'h000000, 1'b1, 3'b010, 32'h8000_0000, 1'b1));
    send_item(mk_item(MODE_CLEAR, 24'hFFFFFF, 1'b1, 3'b111, 32'hFFFF_FFFF, 1'b1));

    // random sweeps, one expiry setting per segment
    expiry_set[0] = 32'd1000;
    expiry_set[1] = 32'h0;
    expiry_set[2] = EXPIRY_RESET;
    expiry_set[3] = 32'hFFFF_FFFF;
    expiry_set[4] = $urandom;
    expiry_set[5] = 32'd50;
    cur_ms        = $urandom;
    for (int s = 0; s < SEGMENTS; s++) begin
      wait_drained();
      send_idle_pct  = (s < 2) ? 38 : (s < 4) ? 85 : 0;
      recv_stall_pct = (s < 2) ? 85 : (s < 4) ? 38 : 0;
      exp_now        = expiry_set[s];
      write_expiry(exp_now);
      // more addresses than slots so eviction happens
      fleet[0] = '0;
      fleet[1] = '1;
      for (int i = 2; i < FLEET; i++) begin
        fleet[i] = $urandom;
      end
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (n % 100 == 60) begin
          wait_drained();
        end
        // advance time: often not at all, mostly inside the expiry, now and then a jump
        r = $urandom_range(0, 99);
        if (r < 20) begin
          span = 32'h0;
        end else if (r < 70) begin
          span = (exp_now < 32'd16) ? 32'd3 : exp_now >> 3;
          span = $urandom_range(0, span);
        end else if (r < 95) begin
          span = $urandom_range(0, (exp_now >> 1) + 32'd3);
        end else begin
          span = $urandom;
        end
        cur_ms = cur_ms + span;
        addr   = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                             : fleet[$urandom_range(0, FLEET - 1)];
        r = $urandom_range(0, 99);
        if (r < 88) begin
          mode = MODE_AIRCRAFT;
        end else if (r < 96) begin
          mode = MODE_CONSUME;
        end else if (r < 97) begin
          mode = MODE_CLEAR;
        end else begin
          mode = MODE_IGNORED;
        end
        send_item(mk_item(mode, addr, ($urandom_range(0, 9) != 0), 3'($urandom_range(0, 7)),
                          cur_ms, 1'($urandom_range(0, 1))));
      end
    end

    // drain, let the block settle, then give the verdict
    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("tb_alert_dedup_table_top: clean");
    end else begin
      $display("tb_alert_dedup_table_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
sv/adt_pkg.sv
sv/adt_ram.sv
sv/alert_dedup_table_top.sv
sv/adt_checker.sv
sim/alert_dedup_checker.sv
sim/tb_alert_dedup_table_top.sv
